// ===== hw/rtl/ores_pkg.sv =====
package ores_pkg;

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_START        = 2'd0;
  localparam logic [1:0] OP_RESET_DONE   = 2'd1;
  localparam logic [1:0] OP_TRIPLET_DONE = 2'd2;

  // Start modes.
  localparam logic [2:0] MODE_FIRST       = 3'd0;
  localparam logic [2:0] MODE_NEXT        = 3'd1;
  localparam logic [2:0] MODE_TARGET      = 3'd2;
  localparam logic [2:0] MODE_SKIP_FAMILY = 3'd3;
  localparam logic [2:0] MODE_VERIFY      = 3'd4;

  // Result kinds.
  localparam logic [1:0] KIND_BUS_RESET = 2'd0;
  localparam logic [1:0] KIND_TRIPLET   = 2'd1;
  localparam logic [1:0] KIND_DONE      = 2'd2;

  // Finish status codes.
  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_SHORT     = 3'd2;
  localparam logic [2:0] ST_BUS_ERROR = 3'd3;
  localparam logic [2:0] ST_ORDER     = 3'd4;

  localparam logic [6:0] ROM_BITS     = 7'd64;
  localparam logic [6:0] FAMILY_LIMIT = 7'd9;
  localparam logic [7:0] CRC_POLY     = 8'h8C;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  mode;
    logic [7:0]  family;
    logic [63:0] given_rom;
    logic        presence;
    logic        short_detected;
    logic        bus_fail;
    logic        id_bit;
    logic        complement_bit;
    logic        taken_direction;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        send_search_command;
    logic        direction;
    logic [2:0]  status;
    logic [63:0] rom_found;
  } result_t;

endpackage

// ===== hw/rtl/ores_ifs.sv =====
interface ores_item_if;
  logic            valid;
  logic            ready;
  ores_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ores_result_if;
  logic              valid;
  logic              ready;
  ores_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/onewire_rom_search_engine_unit.sv =====
// Channel | Dir | Carries
// --------+-----+------------------------------------------------------------
// req     | in  | start / bus reset outcome / triplet outcome transactions
// rsp     | out | bus reset request, triplet request or search finished
//
// One result per transaction, and one transaction per cycle when rsp is ready.
// A transaction passes through an input register, then the search step and the
// result register, which also updates the search state.
// Reset (rst, synchronous) empties both registers and restores the search state.
// While rsp is stalled the result holds; one more transaction waits in the
// input register, after which req.ready drops.
module onewire_rom_search_engine_unit (
  input  logic          clk,
  input  logic          rst,
  ores_item_if.sink     req,
  ores_result_if.source rsp
);

  typedef enum logic [1:0] {PH_IDLE, PH_RESET, PH_TRIPLET} phase_t;

  function automatic logic pick_dir(input logic [6:0] b, input logic [6:0] ld,
                                    input logic [63:0] rom);
    logic [5:0] idx;
    idx = 6'(b - 7'd1);
    if (b < ld) begin
      return rom[idx];
    end
    return b == ld;
  endfunction

  // Pipeline registers.
  logic              in_valid;
  ores_pkg::item_t   in_item;
  logic              out_valid;
  ores_pkg::result_t out_data;

  // Search state.
  logic [63:0] rom_number, rom_number_next;
  logic [63:0] wanted_rom, wanted_rom_next;
  logic [6:0]  last_discrep, last_discrep_next;
  logic [3:0]  family_discrep, family_discrep_next;
  logic        last_device, last_device_next;
  logic [6:0]  bit_number, bit_number_next;
  logic [6:0]  newest_zero_pos, newest_zero_pos_next;
  logic [7:0]  crc_acc, crc_acc_next;
  phase_t      phase, phase_next;
  logic        verifying, verifying_next;

  ores_pkg::result_t res;
  logic              advance;
  logic [6:0]        bit_inc;
  logic [5:0]        pos;
  logic [6:0]        pick_bit;
  logic              dir_pick;
  logic [63:0]       rom_wr;
  logic              crc_fb;
  logic [7:0]        crc_step;
  logic [6:0]        lzp_new;
  logic [3:0]        fd_new;
  logic              start_last;

  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  assign bit_inc  = bit_number + 7'd1;
  assign pos      = 6'(bit_number - 7'd1);
  // A triplet request follows either a reset outcome (current bit) or a
  // triplet outcome (next bit). The write at the current bit never touches
  // the bit read for the next one, so the old ROM serves both cases.
  assign pick_bit = (in_item.op == ores_pkg::OP_TRIPLET_DONE) ? bit_inc : bit_number;
  assign dir_pick = pick_dir(pick_bit, last_discrep, rom_number);

  always_comb begin
    rom_wr      = rom_number;
    rom_wr[pos] = in_item.taken_direction;
  end

  // The Dallas CRC8 run one bit at a time, LSB first, matches the bytewise
  // form at every byte boundary, which is where the result is looked at.
  assign crc_fb   = crc_acc[0] ^ in_item.taken_direction;
  assign crc_step = {1'b0, crc_acc[7:1]} ^ (crc_fb ? ores_pkg::CRC_POLY : 8'h00);

  always_comb begin
    lzp_new = newest_zero_pos;
    fd_new  = family_discrep;
    if (!in_item.id_bit && !in_item.complement_bit && !in_item.taken_direction) begin
      lzp_new = bit_number;
      if (bit_number < ores_pkg::FAMILY_LIMIT) begin
        fd_new = bit_number[3:0];
      end
    end
  end

  always_comb begin
    unique case (in_item.mode)
      ores_pkg::MODE_NEXT:        start_last = last_device;
      ores_pkg::MODE_SKIP_FAMILY: start_last = last_device || (family_discrep == 4'd0);
      default:                    start_last = 1'b0;
    endcase
  end

  always_comb begin
    rom_number_next      = rom_number;
    wanted_rom_next      = wanted_rom;
    last_discrep_next    = last_discrep;
    family_discrep_next  = family_discrep;
    last_device_next     = last_device;
    bit_number_next      = bit_number;
    newest_zero_pos_next = newest_zero_pos;
    crc_acc_next         = crc_acc;
    phase_next           = phase;
    verifying_next       = verifying;
    res.kind                = ores_pkg::KIND_DONE;
    res.send_search_command = 1'b0;
    res.direction           = 1'b0;
    res.status              = ores_pkg::ST_ORDER;

    unique case (in_item.op)
      ores_pkg::OP_START: begin
        if (in_item.mode <= ores_pkg::MODE_VERIFY) begin
          unique case (in_item.mode)
            ores_pkg::MODE_FIRST: begin
              last_discrep_next   = 7'd0;
              family_discrep_next = 4'd0;
            end
            ores_pkg::MODE_TARGET: begin
              rom_number_next     = {56'd0, in_item.family};
              last_discrep_next   = ores_pkg::ROM_BITS;
              family_discrep_next = 4'd0;
            end
            ores_pkg::MODE_SKIP_FAMILY: begin
              last_discrep_next   = {3'd0, family_discrep};
              family_discrep_next = 4'd0;
            end
            ores_pkg::MODE_VERIFY: begin
              rom_number_next     = in_item.given_rom;
              wanted_rom_next     = in_item.given_rom;
              last_discrep_next   = ores_pkg::ROM_BITS;
              family_discrep_next = 4'd0;
            end
            default: begin
            end
          endcase
          last_device_next     = start_last;
          verifying_next       = (in_item.mode == ores_pkg::MODE_VERIFY);
          bit_number_next      = 7'd1;
          newest_zero_pos_next = 7'd0;
          crc_acc_next         = 8'd0;
          if (start_last) begin
            // The previous search already reached the last device, or (skip family) no family discrepancy is left.
            last_discrep_next   = 7'd0;
            family_discrep_next = 4'd0;
            last_device_next    = 1'b0;
            verifying_next      = 1'b0;
            phase_next          = PH_IDLE;
            res.status          = ores_pkg::ST_NOT_FOUND;
          end else begin
            phase_next = PH_RESET;
            res.kind   = ores_pkg::KIND_BUS_RESET;
            res.status = ores_pkg::ST_FOUND;
          end
        end
      end

      ores_pkg::OP_RESET_DONE: begin
        if (phase == PH_RESET) begin
          phase_next     = PH_IDLE;
          verifying_next = 1'b0;
          if (in_item.bus_fail) begin
            res.status = ores_pkg::ST_BUS_ERROR;
          end else if (in_item.short_detected) begin
            res.status = ores_pkg::ST_SHORT;
          end else if (!in_item.presence) begin
            last_discrep_next   = 7'd0;
            family_discrep_next = 4'd0;
            last_device_next    = 1'b0;
            res.status          = ores_pkg::ST_NOT_FOUND;
          end else begin
            phase_next              = PH_TRIPLET;
            verifying_next          = verifying;
            res.kind                = ores_pkg::KIND_TRIPLET;
            res.send_search_command = 1'b1;
            res.direction           = dir_pick;
            res.status              = ores_pkg::ST_FOUND;
          end
        end
      end

      ores_pkg::OP_TRIPLET_DONE: begin
        if (phase == PH_TRIPLET && bit_number >= 7'd1 && bit_number <= ores_pkg::ROM_BITS) begin
          if (in_item.bus_fail) begin
            phase_next     = PH_IDLE;
            verifying_next = 1'b0;
            res.status     = ores_pkg::ST_BUS_ERROR;
          end else if (in_item.id_bit && in_item.complement_bit) begin
            // No device answered this bit.
            last_discrep_next   = 7'd0;
            family_discrep_next = 4'd0;
            last_device_next    = 1'b0;
            phase_next          = PH_IDLE;
            verifying_next      = 1'b0;
            res.status          = ores_pkg::ST_NOT_FOUND;
          end else begin
            rom_number_next      = rom_wr;
            crc_acc_next         = crc_step;
            newest_zero_pos_next = lzp_new;
            family_discrep_next  = fd_new;
            bit_number_next      = bit_inc;
            if (bit_number != ores_pkg::ROM_BITS) begin
              res.kind      = ores_pkg::KIND_TRIPLET;
              res.direction = dir_pick;
              res.status    = ores_pkg::ST_FOUND;
            end else begin
              phase_next     = PH_IDLE;
              verifying_next = 1'b0;
              if (crc_step != 8'd0 || rom_wr[7:0] == 8'd0) begin
                last_discrep_next   = 7'd0;
                family_discrep_next = 4'd0;
                last_device_next    = 1'b0;
                res.status          = ores_pkg::ST_NOT_FOUND;
              end else begin
                last_discrep_next = lzp_new;
                last_device_next  = last_device || (lzp_new == 7'd0);
                if (verifying && rom_wr != wanted_rom) begin
                  res.status = ores_pkg::ST_NOT_FOUND;
                end else begin
                  res.status = ores_pkg::ST_FOUND;
                end
              end
            end
          end
        end
      end

      default: begin
      end
    endcase

    res.rom_found = rom_number_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid        <= 1'b0;
      out_valid       <= 1'b0;
      rom_number      <= 64'd0;
      wanted_rom      <= 64'd0;
      last_discrep    <= 7'd0;
      family_discrep  <= 4'd0;
      last_device     <= 1'b0;
      bit_number      <= 7'd1;
      newest_zero_pos <= 7'd0;
      crc_acc         <= 8'd0;
      phase           <= PH_IDLE;
      verifying       <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        in_valid <= 1'b1;
        in_item  <= req.data;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid       <= 1'b1;
        out_data        <= res;
        rom_number      <= rom_number_next;
        wanted_rom      <= wanted_rom_next;
        last_discrep    <= last_discrep_next;
        family_discrep  <= family_discrep_next;
        last_device     <= last_device_next;
        bit_number      <= bit_number_next;
        newest_zero_pos <= newest_zero_pos_next;
        crc_acc         <= crc_acc_next;
        phase           <= phase_next;
        verifying       <= verifying_next;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/ores_checker.sv =====
module ores_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input ores_pkg::result_t rsp_data
);

  // Transactions taken in but whose result has not yet been delivered.
  logic [1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else begin
      pending <= pending + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
    end
  end

  // The engine holds at most two transactions: one in each register.
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= 2'd2)
    else $error("more transactions in flight than the engine can hold");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("result shown with no transaction outstanding");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    pending == 2'd0 |-> req_ready)
    else $error("empty engine refuses a transaction");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("stalled result changed or dropped");

endmodule

bind onewire_rom_search_engine_unit ores_checker u_ores_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
